### hdl/mslvo_pkg.sv
`timescale 1ns / 1ps

package mslvo_pkg;

    localparam int RGB_W        = 24;
    localparam int POS_W        = 10;
    localparam int CFG_DATA_W   = 11;
    localparam int CFG_IDX_W    = 1;
    localparam int MIN_DIM      = 3;
    localparam int RESET_WIDTH  = 640;
    localparam int RESET_HEIGHT = 480;

    // cell store word: one bit per cell, bit-enable writes
    localparam int STORE_WORD_W = 64;
    localparam int STORE_OFF_W  = 6;

    localparam logic [RGB_W-1:0] WHITE_RGB = 24'hFF_FFFF;

    typedef enum logic
    {
        CMD_PIXEL = 1'b0,
        CMD_CLEAR = 1'b1
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        REG_ACTIVE_WIDTH  = 1'b0,
        REG_ACTIVE_HEIGHT = 1'b1
    } reg_idx_t;

    // status of the store sweep toward the pixel path
    typedef struct packed
    {
        logic busy;        // sweep in progress, no beats taken
        logic line_clear;  // zero the line memory at the sweep column this cycle
    } sweep_stat_t;

endpackage

### hdl/mslvo_line_ram.sv
`timescale 1ns / 1ps

module mslvo_line_ram
    import mslvo_pkg::*;
#(
    parameter int DEPTH  = 1024,
    parameter int DATA_W = 26
)
(
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hdl/mslvo_gen_store.sv
`timescale 1ns / 1ps

module mslvo_gen_store
    import mslvo_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    localparam int CELLS       = MAX_WIDTH * MAX_HEIGHT,
    localparam int STORE_WORDS = (CELLS + STORE_WORD_W - 1) / STORE_WORD_W,
    localparam int ADDR_W      = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1,
    localparam int IDX_W       = ADDR_W + STORE_OFF_W,
    localparam int COL_W       = $clog2(MAX_WIDTH)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [IDX_W-1:0]  rd_idx,
    output logic              rd_bit,
    input  logic              wr_en,
    input  logic [IDX_W-1:0]  wr_idx,
    input  logic              wr_bit,
    input  logic              clear_start,
    output sweep_stat_t       stat,
    output logic [COL_W-1:0]  sweep_col
);

    localparam int SWEEP_LEN = (STORE_WORDS > MAX_WIDTH) ? STORE_WORDS : MAX_WIDTH;
    localparam int CNT_W     = $clog2(SWEEP_LEN);
    localparam logic [CNT_W-1:0] SWEEP_LAST = CNT_W'(SWEEP_LEN - 1);
    localparam logic [CNT_W-1:0] STORE_LAST = CNT_W'(STORE_WORDS - 1);
    localparam logic [CNT_W-1:0] LINE_LAST  = CNT_W'(MAX_WIDTH - 1);

    logic [STORE_WORD_W-1:0] mem [STORE_WORDS];
    logic [STORE_WORD_W-1:0] rd_word_reg;
    logic [STORE_OFF_W-1:0]  rd_off_reg;

    logic             busy_reg, busy_next;
    logic             init_reg, init_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             sweep_wr;

    // sweep sequencer: one word per cycle; line memories only after reset
    always_comb
    begin
        busy_next = busy_reg;
        init_next = init_reg;
        cnt_next  = cnt_reg;
        if (busy_reg)
        begin
            if (cnt_reg == SWEEP_LAST)
            begin
                busy_next = 1'b0;
                init_next = 1'b0;
                cnt_next  = '0;
            end
            else
            begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end
        else if (clear_start)
        begin
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            init_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            init_reg <= init_next;
            cnt_reg  <= cnt_next;
        end
    end

    assign sweep_wr        = busy_reg && (cnt_reg <= STORE_LAST);
    assign stat.busy       = busy_reg;
    assign stat.line_clear = busy_reg && init_reg && (cnt_reg <= LINE_LAST);
    assign sweep_col       = cnt_reg[COL_W-1:0];

    always_ff @(posedge clk)
    begin
        if (sweep_wr)
        begin
            mem[cnt_reg[ADDR_W-1:0]] <= '0;
        end
        else if (wr_en)
        begin
            mem[wr_idx[IDX_W-1:STORE_OFF_W]][wr_idx[STORE_OFF_W-1:0]] <= wr_bit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_word_reg <= mem[rd_idx[IDX_W-1:STORE_OFF_W]];
            rd_off_reg  <= rd_idx[STORE_OFF_W-1:0];
        end
    end

    assign rd_bit = rd_word_reg[rd_off_reg];

endmodule

### hdl/mslvo_life_window.sv
`timescale 1ns / 1ps

module mslvo_life_window
    import mslvo_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       shift,
    input  logic [2:0] new_col,   // bit 0 top, bit 1 middle, bit 2 current row
    output logic       alive
);

    logic [2:0] col_a_reg;   // oldest column kept
    logic [2:0] col_b_reg;   // centre column once new_col is shifted in
    logic [3:0] total;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_a_reg <= '0;
            col_b_reg <= '0;
        end
        else if (shift)
        begin
            col_a_reg <= col_b_reg;
            col_b_reg <= new_col;
        end
    end

    // B3/S23 with the centre counted: 3 lives, 4 keeps a live centre
    assign total = 4'($countones({col_a_reg, col_b_reg, new_col}));
    assign alive = (total == 4'd3) || (col_b_reg[1] && (total == 4'd4));

endmodule

### hdl/motion_seeded_life_video_overlay.sv
// Motion-seeded Life overlay for a raster pixel stream.
// Input channel (in_valid/in_ready): one beat per pixel in raster order with
// cmd, motion and source_rgb. cmd = clear empties the cell store.
// Output channel (out_valid/out_ready): one beat per interior pixel, white
// where the new Life cell lives, else the delayed source colour, tagged with
// out_column/out_row and frame_last. A result for pixel (r-1, c-1) leaves with
// the beat of input pixel (r, c); border pixels give no beat.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): active_width and
// active_height, always ready; write only while the block is idle.
// Results pass the stage-1 and output registers; one pixel per clock while
// in_ready is high. A pixel reads the cell store, reads and writes the line
// memory (two line bits plus colour), and writes a cell only with a result.
// Receiver stall: one item waits in the read stage behind the output
// register, then in_ready drops until out_ready returns.
// Reset and clear: a sweep zeroes the cell store one 64-cell word per cycle;
// the sweep after reset also zeroes the line memory. in_ready is low
// throughout; config writes are still taken.
`timescale 1ns / 1ps

module motion_seeded_life_video_overlay
    import mslvo_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  cmd,
    input  logic                  motion,
    input  logic [RGB_W-1:0]      source_rgb,

    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [RGB_W-1:0]      out_rgb,
    output logic [POS_W-1:0]      out_column,
    output logic [POS_W-1:0]      out_row,
    output logic                  frame_last,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(MAX_HEIGHT);
    localparam int CELLS       = MAX_WIDTH * MAX_HEIGHT;
    localparam int STORE_WORDS = (CELLS + STORE_WORD_W - 1) / STORE_WORD_W;
    localparam int ADDR_W      = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
    localparam int IDX_W       = ADDR_W + STORE_OFF_W;
    localparam int LINE_W      = RGB_W + 2;
    localparam int RST_W       = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;
    localparam int RST_H       = (RESET_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RESET_HEIGHT;

    // line memory word: [LINE_W-1] two rows up, [RGB_W] one row up, colour below
    localparam int LB_TOP = LINE_W - 1;
    localparam int LB_MID = RGB_W;

    // ---------------------------------------------------------------
    // Configuration: kept as clamped last column / last row
    // ---------------------------------------------------------------
    logic [COL_W-1:0] w_last_reg, w_last_next;
    logic [ROW_W-1:0] h_last_reg, h_last_next;
    logic [COL_W-1:0] cfg_w_last;
    logic [ROW_W-1:0] cfg_h_last;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_w_last = COL_W'(MAX_WIDTH - 1);
        if (cfg_data < CFG_DATA_W'(MIN_DIM))
        begin
            cfg_w_last = COL_W'(MIN_DIM - 1);
        end
        else if (32'(cfg_data) <= MAX_WIDTH)
        begin
            cfg_w_last = COL_W'(cfg_data - CFG_DATA_W'(1));
        end

        cfg_h_last = ROW_W'(MAX_HEIGHT - 1);
        if (cfg_data < CFG_DATA_W'(MIN_DIM))
        begin
            cfg_h_last = ROW_W'(MIN_DIM - 1);
        end
        else if (32'(cfg_data) <= MAX_HEIGHT)
        begin
            cfg_h_last = ROW_W'(cfg_data - CFG_DATA_W'(1));
        end
    end

    always_comb
    begin
        w_last_next = w_last_reg;
        h_last_next = h_last_reg;
        if (cfg_valid)
        begin
            case (reg_idx_t'(cfg_index))
                REG_ACTIVE_WIDTH:  w_last_next = cfg_w_last;
                REG_ACTIVE_HEIGHT: h_last_next = cfg_h_last;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_last_reg <= COL_W'(RST_W - 1);
            h_last_reg <= ROW_W'(RST_H - 1);
        end
        else
        begin
            w_last_reg <= w_last_next;
            h_last_reg <= h_last_next;
        end
    end

    // ---------------------------------------------------------------
    // Stage 0: position, flags, memory read issue
    // ---------------------------------------------------------------
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] c0;
    logic [ROW_W-1:0] r0;
    logic [ROW_W:0]   row_inc;
    logic             border0, emit0, last0;
    logic [IDX_W-1:0] idx0;
    logic             in_fire;
    logic             pix_accept;

    sweep_stat_t      sweep_stat;
    logic [COL_W-1:0] sweep_col;

    // a width or height shrunk by a config write may leave the position out of range
    always_comb
    begin
        if (col_reg > w_last_reg)
        begin
            c0      = '0;
            row_inc = {1'b0, row_reg} + (ROW_W+1)'(1);
        end
        else
        begin
            c0      = col_reg;
            row_inc = {1'b0, row_reg};
        end
        r0 = (row_inc > {1'b0, h_last_reg}) ? '0 : row_inc[ROW_W-1:0];
    end

    assign border0 = (r0 == '0) || (r0 == h_last_reg) || (c0 == '0) || (c0 == w_last_reg);
    assign emit0   = (r0 >= ROW_W'(2)) && (c0 >= COL_W'(2));
    assign last0   = (r0 == h_last_reg) && (c0 == w_last_reg);
    assign idx0    = IDX_W'(r0) * IDX_W'(MAX_WIDTH) + IDX_W'(c0);

    always_comb
    begin
        if (c0 == w_last_reg)
        begin
            col_next = '0;
            row_next = (r0 == h_last_reg) ? '0 : r0 + ROW_W'(1);
        end
        else
        begin
            col_next = c0 + COL_W'(1);
            row_next = r0;
        end
    end

    assign pix_accept = in_fire && (cmd == CMD_PIXEL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (pix_accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: memory data back, Life update, write-back
    // ---------------------------------------------------------------
    logic              s1_valid_reg, s1_valid_next;
    logic              s1_clear_reg;
    logic              s1_emit_reg;
    logic              s1_border_reg;
    logic              s1_last_reg;
    logic              s1_motion_reg;
    logic [RGB_W-1:0]  s1_rgb_reg;
    logic [COL_W-1:0]  s1_col_reg;
    logic [POS_W-1:0]  s1_out_col_reg;
    logic [POS_W-1:0]  s1_out_row_reg;
    logic [IDX_W-1:0]  s1_wr_idx_reg;

    logic              s1_fire;
    logic              s1_pix_fire;
    logic              s1_result;
    logic              store_bit;
    logic [LINE_W-1:0] line_rd;
    logic              cur1, top1, mid1;
    logic              alive;
    logic [RGB_W-1:0]  hold_reg;

    logic              out_valid_reg, out_valid_next;
    logic [RGB_W-1:0]  out_rgb_reg;
    logic [POS_W-1:0]  out_col_reg;
    logic [POS_W-1:0]  out_row_reg;
    logic              out_last_reg;

    logic              store_wr_en;
    logic              line_wr_en;
    logic [COL_W-1:0]  line_wr_addr;
    logic [LINE_W-1:0] line_wr_data;

    // only result-bearing items wait on the output register
    assign s1_fire     = s1_valid_reg && (!s1_emit_reg || !out_valid_reg || out_ready);
    assign s1_pix_fire = s1_fire && !s1_clear_reg;
    assign s1_result   = s1_pix_fire && s1_emit_reg;

    // a clear waiting in stage 1 holds off new pixels until the sweep owns the store
    assign in_ready = !sweep_stat.busy && !(s1_valid_reg && s1_clear_reg)
                      && (!s1_valid_reg || s1_fire);
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_clear_reg <= 1'b0;
            s1_emit_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (in_fire)
            begin
                s1_clear_reg <= (cmd == CMD_CLEAR);
                s1_emit_reg  <= (cmd == CMD_PIXEL) && emit0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_border_reg  <= border0;
            s1_last_reg    <= last0;
            s1_motion_reg  <= motion;
            s1_rgb_reg     <= source_rgb;
            s1_col_reg     <= c0;
            s1_out_col_reg <= POS_W'(c0 - COL_W'(1));
            s1_out_row_reg <= POS_W'(r0 - ROW_W'(1));
            s1_wr_idx_reg  <= idx0 - IDX_W'(MAX_WIDTH + 1);
        end
    end

    // border cells are dead whatever motion or the store says
    assign cur1 = !s1_border_reg && (store_bit || s1_motion_reg);
    assign top1 = line_rd[LB_TOP];
    assign mid1 = line_rd[LB_MID];

    mslvo_life_window u_window
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .shift   (s1_pix_fire),
        .new_col ({cur1, mid1, top1}),
        .alive   (alive)
    );

    // colour hold: the line memory gives the colour one row back, the hold one more pixel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg <= '0;
        end
        else if (s1_pix_fire)
        begin
            hold_reg <= line_rd[RGB_W-1:0];
        end
    end

    // ---------------------------------------------------------------
    // Memories
    // ---------------------------------------------------------------
    assign store_wr_en = s1_result;

    mslvo_gen_store #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_store
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .rd_en       (in_fire),
        .rd_idx      (idx0),
        .rd_bit      (store_bit),
        .wr_en       (store_wr_en),
        .wr_idx      (s1_wr_idx_reg),
        .wr_bit      (alive),
        .clear_start (s1_fire && s1_clear_reg),
        .stat        (sweep_stat),
        .sweep_col   (sweep_col)
    );

    // Stage 1 writes column c while stage 0 reads column c+1 (or 0 after a
    // wrap); with at least three columns the two never meet, so no bypass.
    assign line_wr_en   = sweep_stat.line_clear || s1_pix_fire;
    assign line_wr_addr = sweep_stat.line_clear ? sweep_col : s1_col_reg;
    assign line_wr_data = sweep_stat.line_clear ? '0 : {mid1, cur1, s1_rgb_reg};

    mslvo_line_ram #(
        .DEPTH  (MAX_WIDTH),
        .DATA_W (LINE_W)
    ) u_line
    (
        .clk     (clk),
        .rd_en   (in_fire),
        .rd_addr (c0),
        .rd_data (line_rd),
        .wr_en   (line_wr_en),
        .wr_addr (line_wr_addr),
        .wr_data (line_wr_data)
    );

    // ---------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_result)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_result)
        begin
            out_rgb_reg  <= alive ? WHITE_RGB : hold_reg;
            out_col_reg  <= s1_out_col_reg;
            out_row_reg  <= s1_out_row_reg;
            out_last_reg <= s1_last_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_rgb    = out_rgb_reg;
    assign out_column = out_col_reg;
    assign out_row    = out_row_reg;
    assign frame_last = out_last_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_no_beat_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        sweep_stat.busy |-> !in_ready)
        else $error("input beat possible during store sweep");

    a_store_wr_not_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        store_wr_en |-> !sweep_stat.busy)
        else $error("cell write collides with store sweep");

    a_line_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_pix_fire && in_fire) |-> (s1_col_reg != c0))
        else $error("line memory read and write hit the same column");

    a_line_clear_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        sweep_stat.line_clear |-> !s1_valid_reg)
        else $error("line memory clear while a pixel is in flight");

endmodule

### test/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import mslvo_pkg::*;

    localparam int          MAX_W            = 1024;
    localparam int          MAX_H            = 1024;
    localparam int          CLK_PERIOD       = 4;
    localparam int          SETTLE_CYCLES    = 8;      // output register plus read stage, with margin
    localparam int          LONG_HOLD_CYCLES = 300;
    localparam int          RANDOM_ITEMS     = 120;
    localparam int          EXTREME_ITEMS    = 30;
    localparam int          REPORT_LIMIT     = 100;
    localparam longint      TIMEOUT_NS       = 64'd40_000_000;

    // overlay result as the block should emit it
    typedef struct
    {
        logic [RGB_W-1:0] rgb;
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
        logic             last;
    } overlay_px_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic                  cmd;
    logic                  motion;
    logic [RGB_W-1:0]      source_rgb;
    logic                  out_valid;
    logic                  out_ready;
    logic [RGB_W-1:0]      out_rgb;
    logic [POS_W-1:0]      out_column;
    logic [POS_W-1:0]      out_row;
    logic                  frame_last;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // ---------------------------------------------------------------
    // Life overlay predictor state: its own copy of the cell store, the
    // two cell lines, the colour line, the 3x3 window and the position.
    // ---------------------------------------------------------------
    bit                    gen_cells   [MAX_W*MAX_H];
    bit                    line_cells  [2*MAX_W];
    logic [RGB_W-1:0]      colour_line [MAX_W+1];
    logic [2:0]            win_cols    [3];
    int unsigned           pos_col;
    int unsigned           pos_row;
    logic [CFG_DATA_W-1:0] reg_width;
    logic [CFG_DATA_W-1:0] reg_height;

    overlay_px_t           pending_overlay[$];

    // run bookkeeping
    int unsigned fail_count;
    int unsigned pixels_sent;
    int unsigned clears_sent;
    int unsigned results_checked;
    int unsigned settings_used;
    bit          steady_flow;   // no random gaps on either side while set
    bit          hold_output;   // receiver takes one long hold-off, then clears it

    motion_seeded_life_video_overlay #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .motion     (motion),
        .source_rgb (source_rgb),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_rgb    (out_rgb),
        .out_column (out_column),
        .out_row    (out_row),
        .frame_last (frame_last),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #(CLK_PERIOD/2) clk = ~clk;

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------
    function automatic int unsigned clamp_dim(logic [CFG_DATA_W-1:0] v, int unsigned hi);
        if (v < MIN_DIM)
            return MIN_DIM;
        if (v > hi)
            return hi;
        return 32'(v);
    endfunction

    function automatic void clear_generation();
        foreach (gen_cells[i])
            gen_cells[i] = 1'b0;
    endfunction

    // One pixel beat: seed the stored cell with motion, shift the window,
    // and queue the overlay for the pixel one row and one column back.
    function automatic void advance_life(logic mot, logic [RGB_W-1:0] rgb);
        int unsigned      w;
        int unsigned      h;
        int unsigned      c;
        int unsigned      r;
        int unsigned      total;
        bit               on_rim;
        bit               cur;
        bit               top;
        bit               mid;
        bit               centre;
        bit               alive;
        logic [RGB_W-1:0] held;
        overlay_px_t      px;

        w = clamp_dim(reg_width, MAX_W);
        h = clamp_dim(reg_height, MAX_H);
        // a geometry change can leave the position outside the frame
        if (pos_col >= w)
        begin
            pos_col = 0;
            pos_row++;
        end
        if (pos_row >= h)
            pos_row = 0;
        c = pos_col;
        r = pos_row;

        // rim cells are dead no matter what motion or the store says
        on_rim = (r == 0) || (r == h - 1) || (c == 0) || (c == w - 1);
        cur    = on_rim ? 1'b0 : (gen_cells[r*MAX_W + c] | mot);

        top = line_cells[MAX_W + c];
        mid = line_cells[c];
        line_cells[MAX_W + c] = mid;
        line_cells[c]         = cur;

        win_cols[0] = win_cols[1];
        win_cols[1] = win_cols[2];
        win_cols[2] = {cur, mid, top};

        held               = colour_line[MAX_W];
        colour_line[MAX_W] = colour_line[c];
        colour_line[c]     = rgb;

        if (r >= 2 && c >= 2)
        begin
            total  = $countones(win_cols[0]) + $countones(win_cols[1])
                   + $countones(win_cols[2]);
            centre = win_cols[1][1];
            // B3/S23 with the centre counted in the total
            alive  = (total == 3) || (centre && total == 4);
            gen_cells[(r - 1)*MAX_W + (c - 1)] = alive;
            px.rgb  = alive ? WHITE_RGB : held;
            px.col  = POS_W'(c - 1);
            px.row  = POS_W'(r - 1);
            px.last = (r - 1 == h - 2) && (c - 1 == w - 2);
            pending_overlay.push_back(px);
        end

        pos_col = c + 1;
        if (pos_col >= w)
        begin
            pos_col = 0;
            pos_row = r + 1;
            if (pos_row >= h)
                pos_row = 0;
        end
    endfunction

    function automatic int unsigned frame_pixels();
        return clamp_dim(reg_width, MAX_W) * clamp_dim(reg_height, MAX_H);
    endfunction

    // pixels left until the position is back at the top-left corner
    function automatic int unsigned pixels_to_frame_end();
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;

        w = clamp_dim(reg_width, MAX_W);
        h = clamp_dim(reg_height, MAX_H);
        c = pos_col;
        r = pos_row;
        if (c >= w)
        begin
            c = 0;
            r++;
        end
        if (r >= h)
            r = 0;
        if (c == 0 && r == 0)
            return 0;
        return w*h - (r*w + c);
    endfunction

    // ---------------------------------------------------------------
    // Idle lengths: mostly short, a few long
    // ---------------------------------------------------------------
    function automatic int unsigned idle_len();
        int unsigned pick;

        pick = $urandom_range(0, 99);
        if (pick < 75)
            return $urandom_range(1, 3);
        if (pick < 95)
            return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    function automatic int unsigned pick_gap();
        if (steady_flow || $urandom_range(0, 99) < 60)
            return 0;
        return idle_len();
    endfunction

    function automatic logic [RGB_W-1:0] pick_rgb();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return WHITE_RGB;
            default: return RGB_W'($urandom());
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Sender side. Valid stays high after a beat; the next call either
    // changes the payload at the next falling edge or drops valid for a gap.
    // ---------------------------------------------------------------
    task automatic send_beat(input cmd_t op, input logic mot, input logic [RGB_W-1:0] rgb);
        int unsigned gap;

        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        cmd        <= op;
        motion     <= mot;
        source_rgb <= rgb;
        do @(posedge clk); while (in_ready !== 1'b1);
        if (op == CMD_CLEAR)
        begin
            clear_generation();
            clears_sent++;
        end
        else
        begin
            advance_life(mot, rgb);
            pixels_sent++;
        end
    endtask

    task automatic stream_pixels(input int unsigned count, input int unsigned motion_pct,
                                 input bit stray_clear);
        for (int unsigned k = 0; k < count; k++)
        begin
            // rare clear in the middle of a frame
            if (stray_clear && $urandom_range(0, 299) == 0)
                send_beat(CMD_CLEAR, 1'($urandom_range(0, 1)), pick_rgb());
            send_beat(CMD_PIXEL, $urandom_range(0, 99) < motion_pct, pick_rgb());
        end
    endtask

    task automatic finish_frame(input int unsigned motion_pct);
        stream_pixels(pixels_to_frame_end(), motion_pct, 1'b0);
    endtask

    // drop valid and wait until every queued overlay beat has come back
    task automatic drain_overlay();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_overlay.size() != 0)
            @(posedge clk);
        // a rim pixel may still sit in the read stage with no beat to show for it
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        if (idx == REG_ACTIVE_WIDTH)
            reg_width = value;
        else
            reg_height = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_geometry(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
        write_reg(REG_ACTIVE_WIDTH, w);
        write_reg(REG_ACTIVE_HEIGHT, h);
        settings_used++;
    endtask

    // ---------------------------------------------------------------
    // Receiver: random stalls, plus one long hold-off on request
    // ---------------------------------------------------------------
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_output)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge clk);
                hold_output = 1'b0;
                out_ready <= 1'b1;
            end
            else if (!steady_flow && $urandom_range(0, 7) == 0)
            begin
                out_ready <= 1'b0;
                repeat (idle_len()) @(negedge clk);
                out_ready <= 1'b1;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------
    // Output checker: every overlay beat against the oldest prediction
    // ---------------------------------------------------------------
    function automatic void flag_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
                $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin : check_overlay
        overlay_px_t want;

        if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
        begin
            if (pending_overlay.size() == 0)
            begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $error("overlay beat with nothing expected: row %0d column %0d",
                           out_row, out_column);
            end
            else
            begin
                want = pending_overlay.pop_front();
                flag_field("out_rgb", 32'(want.rgb), 32'(out_rgb));
                flag_field("out_column", 32'(want.col), 32'(out_column));
                flag_field("out_row", 32'(want.row), 32'(out_row));
                flag_field("frame_last", 32'(want.last), 32'(frame_last));
                results_checked++;
            end
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // reset geometry is 640 wide: a short run along the top row gives no beat
    task automatic test_power_on_geometry();
        stream_pixels(24, 15, 1'b0);
    endtask

    // 5x4 frame seeded by motion: birth, survival at three and four,
    // overcrowding, motion on the rim ignored, colour extremes
    task automatic test_life_patterns();
        bit               seed;
        bit               on_rim;
        logic [RGB_W-1:0] rgb;

        drain_overlay();
        set_geometry(11'd5, 11'd4);
        finish_frame(0);   // carries on under the new geometry
        send_beat(CMD_CLEAR, 1'b1, WHITE_RGB);
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 5; c++)
            begin
                on_rim = (r == 0) || (r == 3) || (c == 0) || (c == 4);
                seed   = on_rim || (r == 1 && c >= 1 && c <= 3) || (r == 2 && c >= 1 && c <= 2);
                case ((r + c) % 3)
                    0:       rgb = '0;
                    1:       rgb = WHITE_RGB;
                    default: rgb = pick_rgb();
                endcase
                send_beat(CMD_PIXEL, seed, rgb);
            end
        end
    endtask

    // width shrinks under the column, then height shrinks under the row
    task automatic test_geometry_change();
        drain_overlay();
        set_geometry(11'd8, 11'd6);
        stream_pixels(30, 30, 1'b0);
        drain_overlay();
        write_reg(REG_ACTIVE_WIDTH, 11'd4);
        stream_pixels(6, 30, 1'b0);
        drain_overlay();
        write_reg(REG_ACTIVE_HEIGHT, 11'd3);
        stream_pixels(10, 30, 1'b0);
        drain_overlay();
        set_geometry(11'd6, 11'd5);
        finish_frame(25);
    endtask

    // receiver holds off while the sender keeps offering, then the sender
    // pauses until everything is back
    task automatic test_backpressure();
        drain_overlay();
        set_geometry(11'd10, 11'd6);
        finish_frame(20);
        steady_flow = 1'b1;
        hold_output = 1'b1;
        stream_pixels(60, 40, 1'b0);
        steady_flow = 1'b0;
        drain_overlay();
        finish_frame(40);
    endtask

    // register extremes at the narrow width and the tall or short height;
    // a short run under each shows the clamped row length
    task automatic test_extreme_geometry();
        logic [CFG_DATA_W-1:0] ext_w [4];
        logic [CFG_DATA_W-1:0] ext_h [4];

        ext_w = '{11'd0, 11'd3, 11'd2, 11'd1};
        ext_h = '{11'd2047, 11'd0, 11'd1024, 11'd1};
        for (int k = 0; k < 4; k++)
        begin
            drain_overlay();
            set_geometry(ext_w[k], ext_h[k]);
            steady_flow = (k % 2 == 1);
            stream_pixels(EXTREME_ITEMS, 25, 1'b0);
        end
        steady_flow = 1'b0;
    endtask

    // small frames with random content, clears at frame boundaries, and
    // now and then a low out-of-range register or a stray clear
    task automatic test_random_frames();
        int unsigned           start_count;
        int unsigned           frames;
        int unsigned           motion_pct;
        logic [CFG_DATA_W-1:0] w;
        logic [CFG_DATA_W-1:0] h;

        start_count = pixels_sent + clears_sent;
        while (pixels_sent + clears_sent - start_count < RANDOM_ITEMS)
        begin
            drain_overlay();
            case ($urandom_range(0, 9))
                0:
                begin
                    w = 11'd3;
                    h = 11'd3;
                end
                1:
                begin
                    w = CFG_DATA_W'($urandom_range(0, 2));
                    h = CFG_DATA_W'($urandom_range(3, 10));
                end
                2:
                begin
                    w = CFG_DATA_W'($urandom_range(3, 12));
                    h = CFG_DATA_W'($urandom_range(0, 2));
                end
                default:
                begin
                    w = CFG_DATA_W'($urandom_range(3, 12));
                    h = CFG_DATA_W'($urandom_range(3, 10));
                end
            endcase
            set_geometry(w, h);
            steady_flow = ($urandom_range(0, 3) == 0);
            // the old frame runs out under the new geometry first
            stream_pixels(pixels_to_frame_end(), 30, 1'b1);
            frames = $urandom_range(1, 2);
            for (int unsigned f = 0; f < frames; f++)
            begin
                if ($urandom_range(0, 4) == 0)
                    send_beat(CMD_CLEAR, 1'($urandom_range(0, 1)), pick_rgb());
                case ($urandom_range(0, 4))
                    0:       motion_pct = 0;
                    1:       motion_pct = 10;
                    2:       motion_pct = 30;
                    3:       motion_pct = 50;
                    default: motion_pct = 100;
                endcase
                stream_pixels(frame_pixels(), motion_pct, 1'b1);
            end
        end
        steady_flow = 1'b0;
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        cmd        = CMD_PIXEL;
        motion     = 1'b0;
        source_rgb = '0;
        cfg_valid  = 1'b0;
        cfg_index  = REG_ACTIVE_WIDTH;
        cfg_data   = '0;

        fail_count      = 0;
        pixels_sent     = 0;
        clears_sent     = 0;
        results_checked = 0;
        settings_used   = 0;
        steady_flow     = 1'b0;
        hold_output     = 1'b0;

        clear_generation();
        foreach (line_cells[i])
            line_cells[i] = 1'b0;
        foreach (colour_line[i])
            colour_line[i] = '0;
        foreach (win_cols[i])
            win_cols[i] = '0;
        pos_col    = 0;
        pos_row    = 0;
        reg_width  = CFG_DATA_W'(RESET_WIDTH);
        reg_height = CFG_DATA_W'(RESET_HEIGHT);

        // the store sweep after reset holds in_ready low; send_beat waits it out
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_power_on_geometry();
        test_life_patterns();
        test_geometry_change();
        test_backpressure();
        test_extreme_geometry();
        test_random_frames();
        drain_overlay();

        $display("Sent %0d pixel beats and %0d clears over %0d frame geometries",
                 pixels_sent, clears_sent, settings_used);
        $display("Checked %0d overlay beats, %0d failures", results_checked, fail_count);
        if (fail_count == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // hang guard, far above the slowest legal run
    initial
    begin
        #(TIMEOUT_NS);
        $display("Timeout with %0d overlay beats still expected", pending_overlay.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
